// ----- src/bounded_sorted_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared forms for concurrent checks, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define BSQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bsq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Payload structs, request and register codes, cell control and ordering.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int MAX_DEPTH_DEF = 16;
  localparam int REQ_W         = 2;
  localparam int CNT_OUT_W     = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  // request codes; the unused code behaves as a query
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

  typedef struct packed {
    logic [REQ_W-1:0]              req_type;
    logic signed [VALUE_WIDTH-1:0] push_value;
  } bsq_req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] front_value;
    logic signed [VALUE_WIDTH-1:0] back_value;
    logic [CNT_OUT_W-1:0]          entry_count;
    logic                          is_empty;
    logic                          dropped_valid;
    logic signed [VALUE_WIDTH-1:0] dropped_value;
    logic                          underflow;
  } bsq_rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_INSERT,
    CELL_APPEND,
    CELL_SORT
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t                      op;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          descending;
  } cell_ctl_t;

  // per-cell position relative to the fill level
  typedef struct packed {
    logic occupied;
    logic at_tail;
    logic pair_lo;
  } cell_pos_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_SORT,
    ST_RESPOND
  } bsq_state_t;

  // true when a must stand behind b under the given order
  function automatic logic after_fn(input logic signed [VALUE_WIDTH-1:0] a,
                                    input logic signed [VALUE_WIDTH-1:0] b,
                                    input logic desc);
    return desc ? (a < b) : (a > b);
  endfunction

endpackage

// ----- src/bsq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry and exchanges it with its neighbours as the op directs.
// ----------------------------------------------------------------------------
module bsq_cell import bsq_pkg::*; (
  input  logic                          clk,
  input  cell_ctl_t                     ctl_i,
  input  cell_pos_t                     pos_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic                          left_before_i,
  input  logic                          left_swap_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic                          before_o,
  output logic                          swap_o
);

  logic signed [VALUE_WIDTH-1:0] entry_r;
  logic signed [VALUE_WIDTH-1:0] entry_nxt;
  logic signed [VALUE_WIDTH-1:0] ins_value;

  // new value goes in front of this entry
  assign before_o  = pos_i.occupied && after_fn(entry_r, ctl_i.value, ctl_i.descending);
  // lower cell of an active pair decides the exchange
  assign swap_o    = pos_i.pair_lo && after_fn(entry_r, right_value_i, ctl_i.descending);
  assign ins_value = left_before_i ? left_value_i : ctl_i.value;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl_i.op)
      CELL_SHIFT: begin
        entry_nxt = right_value_i;
      end
      CELL_INSERT: begin
        if (pos_i.occupied) begin
          if (before_o) begin
            entry_nxt = ins_value;
          end
        end else if (pos_i.at_tail) begin
          entry_nxt = ins_value;
        end
      end
      CELL_APPEND: begin
        if (pos_i.at_tail) begin
          entry_nxt = ctl_i.value;
        end
      end
      CELL_SORT: begin
        if (swap_o) begin
          entry_nxt = right_value_i;
        end else if (left_swap_i) begin
          entry_nxt = left_value_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign value_o = entry_r;

endmodule

// ----- src/bounded_sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Bounded sorted priority queue
// Chain of entry cells kept in order, with a small sequencer and result stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel (valid/ready). req_type push, pop or query;
//           push_value is the value a push inserts.
//   out_* : one result per request: front, back, count, empty, the entry
//           removed by a pop or a full-queue push, and an underflow flag.
//   cfg_* : register writes (index, data), always ready. Index 0 sets the
//           order (1 puts the largest value in front), index 1 the capacity,
//           which is taken only while the queue is empty and saturated to
//           1..MAX_DEPTH.
// Timing:
//   A query or pop is taken, its result is loaded into the result register
//   in the respond state, and only then is the next request taken. A push
//   evicts in the accepting cycle, then does the parallel insert across the
//   cell chain in the place state, then loads the result. After an order
//   change a push instead appends and runs odd-even exchange passes over the
//   chain, one pass per cycle, one pass for each entry then stored.
// Reset leaves the queue empty, ascending, with capacity MAX_DEPTH; no
// clearing pass is needed. A stalled receiver holds the result register;
// the next request is still taken and worked on, waiting to report only.
// ----------------------------------------------------------------------------
`include "bounded_sorted_priority_queue_defines.svh"

module bounded_sorted_priority_queue import bsq_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bsq_req_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bsq_rsp_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

  // control state
  bsq_state_t       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] pass_r, pass_nxt;
  logic             ord_r, ord_nxt;
  logic             sort_ord_r, sort_ord_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request payload and result fields
  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                          drop_v_r, drop_v_nxt;
  logic signed [VALUE_WIDTH-1:0] drop_val_r, drop_val_nxt;
  logic                          uf_r, uf_nxt;
  bsq_rsp_t                      out_data_r, out_data_nxt;

  // cell chain
  cell_ctl_t                     ctl;
  cell_pos_t                     pos_w  [MAX_DEPTH];
  logic signed [VALUE_WIDTH-1:0] val_w  [MAX_DEPTH];
  logic                          bef_w  [MAX_DEPTH];
  logic                          swp_w  [MAX_DEPTH];

  logic [IDX_W-1:0]              back_idx;
  logic [CMP_W-1:0]              cap_req;
  logic [CNT_W-1:0]              cap_sat;
  logic                          accept;
  logic                          full;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_DEPTH; gi++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_value;
      logic                          left_before;
      logic                          left_swap;
      logic signed [VALUE_WIDTH-1:0] right_value;

      // position against the fill level; pairs alternate with the pass
      assign pos_w[gi].occupied = CNT_W'(gi) < cnt_r;
      assign pos_w[gi].at_tail  = CNT_W'(gi) == cnt_r;
      assign pos_w[gi].pair_lo  = (1'(gi % 2) == pass_r[0]) && (CNT_W'(gi + 1) < cnt_r);

      if (gi == 0) begin : g_first
        assign left_value  = '0;
        assign left_before = 1'b0;
        assign left_swap   = 1'b0;
      end else begin : g_inner
        assign left_value  = val_w[gi-1];
        assign left_before = bef_w[gi-1];
        assign left_swap   = swp_w[gi-1];
      end

      if (gi == MAX_DEPTH - 1) begin : g_last
        assign right_value = val_w[gi];
      end else begin : g_body
        assign right_value = val_w[gi+1];
      end

      bsq_cell u_cell (
        .clk           (clk),
        .ctl_i         (ctl),
        .pos_i         (pos_w[gi]),
        .left_value_i  (left_value),
        .left_before_i (left_before),
        .left_swap_i   (left_swap),
        .right_value_i (right_value),
        .value_o       (val_w[gi]),
        .before_o      (bef_w[gi]),
        .swap_o        (swp_w[gi])
      );
    end
  endgenerate

  assign in_ready  = (st_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full      = (cnt_r >= cap_r) && (cnt_r != '0);
  assign back_idx  = IDX_W'(cnt_r - CNT_W'(1));

  // saturate a capacity write to 1..MAX_DEPTH
  always_comb begin
    cap_req = CMP_W'(cfg_data);
    if (cap_req == '0) begin
      cap_sat = CNT_W'(1);
    end else if (cap_req > CMP_W'(MAX_DEPTH)) begin
      cap_sat = CNT_W'(MAX_DEPTH);
    end else begin
      cap_sat = CNT_W'(cap_req);
    end
  end

  // sequencer: next state, cell op and result build
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    cap_nxt       = cap_r;
    pass_nxt      = pass_r;
    ord_nxt       = ord_r;
    sort_ord_nxt  = sort_ord_r;
    val_nxt       = val_r;
    drop_v_nxt    = drop_v_r;
    drop_val_nxt  = drop_val_r;
    uf_nxt        = uf_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl.op         = CELL_HOLD;
    ctl.value      = val_r;
    ctl.descending = ord_r;

    // register writes are to arrive only while idle; the user must keep to this, the block does not enforce it
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORDER: begin
          ord_nxt = cfg_data[0];
        end
        CFG_CAPACITY: begin
          if (cnt_r == '0) begin
            cap_nxt = cap_sat;
          end
        end
        default: begin
          cap_nxt = cap_r;
        end
      endcase
    end

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt      = in_data.push_value;
          drop_v_nxt   = 1'b0;
          drop_val_nxt = '0;
          uf_nxt       = 1'b0;
          st_nxt       = ST_RESPOND;
          case (in_data.req_type)
            REQ_PUSH: begin
              st_nxt = ST_PLACE;
              // full: evict the front first
              if (full) begin
                ctl.op       = CELL_SHIFT;
                cnt_nxt      = cnt_r - CNT_W'(1);
                drop_v_nxt   = 1'b1;
                drop_val_nxt = val_w[0];
              end
            end
            REQ_POP: begin
              if (cnt_r == '0) begin
                uf_nxt = 1'b1;
              end else begin
                ctl.op       = CELL_SHIFT;
                cnt_nxt      = cnt_r - CNT_W'(1);
                drop_v_nxt   = 1'b1;
                drop_val_nxt = val_w[0];
              end
            end
            default: begin
              st_nxt = ST_RESPOND;
            end
          endcase
        end
      end
      ST_PLACE: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        // chain still ordered: insert in one step, else append and resort
        if ((sort_ord_r == ord_r) || (cnt_r <= CNT_W'(1))) begin
          ctl.op       = CELL_INSERT;
          sort_ord_nxt = ord_r;
          st_nxt       = ST_RESPOND;
        end else begin
          ctl.op   = CELL_APPEND;
          pass_nxt = '0;
          st_nxt   = ST_SORT;
        end
      end
      ST_SORT: begin
        ctl.op = CELL_SORT;
        if (pass_r == cnt_r - CNT_W'(1)) begin
          sort_ord_nxt = ord_r;
          st_nxt       = ST_RESPOND;
        end else begin
          pass_nxt = pass_r + CNT_W'(1);
        end
      end
      ST_RESPOND: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.front_value   = (cnt_r != '0) ? val_w[0] : '0;
          out_data_nxt.back_value    = (cnt_r != '0) ? val_w[back_idx] : '0;
          out_data_nxt.entry_count   = CNT_OUT_W'(cnt_r);
          out_data_nxt.is_empty      = (cnt_r == '0);
          out_data_nxt.dropped_valid = drop_v_r;
          out_data_nxt.dropped_value = drop_val_r;
          out_data_nxt.underflow     = uf_r;
          out_valid_nxt              = 1'b1;
          st_nxt                     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= CNT_W'(MAX_DEPTH);
      pass_r      <= '0;
      ord_r       <= 1'b0;
      sort_ord_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      cap_r       <= cap_nxt;
      pass_r      <= pass_nxt;
      ord_r       <= ord_nxt;
      sort_ord_r  <= sort_ord_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    drop_v_r   <= drop_v_nxt;
    drop_val_r <= drop_val_nxt;
    uf_r       <= uf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `BSQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= cap_r, "entry count above capacity")
  `BSQ_ASSERT_NEXT(a_pop_count, accept && (in_data.req_type == REQ_POP) && (cnt_r != '0),
                   cnt_r == $past(cnt_r) - CNT_W'(1), "pop did not remove one entry")
  `BSQ_ASSERT_NEXT(a_sort_count, st_r == ST_SORT, cnt_r == $past(cnt_r),
                   "entry count moved during resort")
  `BSQ_ASSERT_IMP(a_empty_flag, out_valid_r,
                  out_data_r.is_empty == (out_data_r.entry_count == '0),
                  "empty flag disagrees with count")
  `BSQ_ASSERT_IMP(a_drop_uf, out_valid_r,
                  !(out_data_r.dropped_valid && out_data_r.underflow),
                  "drop and underflow reported together")

endmodule
